@@ rtl/pqt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pqt_pkg;

  // One slot of the pending table.
  typedef struct packed {
    logic        valid;
    logic [15:0] id;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  age;
  } entry_t;

  typedef logic [2:0] cell_op_t;

  // Operations broadcast to every cell of the chain.
  localparam cell_op_t OP_HOLD   = 3'd0;
  localparam cell_op_t OP_SHR    = 3'd1;
  localparam cell_op_t OP_MATCH  = 3'd2;
  localparam cell_op_t OP_REMOVE = 3'd3;
  localparam cell_op_t OP_ROT    = 3'd4;
  localparam cell_op_t OP_PACK   = 3'd5;

  typedef struct packed {
    cell_op_t    op;
    logic [15:0] txn_id;
  } cell_ctrl_t;

  // Request codes.
  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_REPLY = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_DROPPED   = 3'd1;
  localparam logic [2:0] ST_MATCHED   = 3'd2;
  localparam logic [2:0] ST_UNMATCHED = 3'd3;
  localparam logic [2:0] ST_TICK      = 3'd4;

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;
  localparam logic [7:0] AGE_MAX       = 8'd255;
  localparam logic [4:0] EVICT_MAX     = 5'd31;

endpackage

`default_nettype wire

@@ rtl/pqt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One slot of the table. It trades its entry with its neighbors as the
// broadcast operation tells it.
module pqt_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  pqt_pkg::cell_ctrl_t     ctrl,
  input  pqt_pkg::entry_t         left_in,
  input  pqt_pkg::entry_t         right_in,
  input  wire logic               kill,
  output pqt_pkg::entry_t         entry,
  output logic                    match,
  output logic                    move
);
  import pqt_pkg::*;

  entry_t entry_next;
  logic   match_next;

  // This cell's entry slides left into an empty neighbor during compaction.
  assign move = entry.valid && !left_in.valid;

  always_comb begin
    entry_next = entry;
    match_next = match;
    unique case (ctrl.op)
      OP_SHR: begin
        entry_next = left_in;
      end
      OP_MATCH: begin
        match_next = entry.valid && (entry.id == ctrl.txn_id);
      end
      OP_REMOVE: begin
        if (kill) begin
          entry_next = right_in;
        end
      end
      OP_ROT: begin
        entry_next = right_in;
      end
      OP_PACK: begin
        if (!entry.valid && right_in.valid) begin
          entry_next = right_in;
        end else if (move) begin
          entry_next.valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
      match <= 1'b0;
    end else begin
      entry <= entry_next;
      match <= match_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pqt_pick.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Finds the newest matching slot. The inclusive prefix OR of the match bits
// marks every slot from the hit onward, which is the set of slots that take
// their right neighbor's entry when the hit is removed.
module pqt_pick #(
  parameter int DEPTH = 16
) (
  input  wire logic [DEPTH-1:0] match,
  input  pqt_pkg::entry_t       ents [DEPTH],
  output logic [DEPTH-1:0]      kill,
  output logic                  hit,
  output logic [31:0]           hit_ip,
  output logic [15:0]           hit_port
);
  import pqt_pkg::*;

  localparam int LV = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] lvl [LV+1];
  logic [DEPTH-1:0] first;

  always_comb begin
    lvl[0] = match;
    for (int k = 0; k < LV; k++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << k)) begin
          lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
        end else begin
          lvl[k+1][i] = lvl[k][i];
        end
      end
    end
  end

  assign kill = lvl[LV];
  assign hit  = |match;

  always_comb begin
    first    = '0;
    hit_ip   = '0;
    hit_port = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        first[i] = match[i];
      end else begin
        first[i] = match[i] && !kill[i-1];
      end
      if (first[i]) begin
        hit_ip   = hit_ip | ents[i].ip;
        hit_port = hit_port | ents[i].port;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pending_query_tracker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Beat contents
// in        input      in_valid / in_stall  req_type, txn_id, client_ip, client_port
// out       output     out_valid / out_stall status, reply_ip, reply_port, evicted_count
// cfg       input      cfg_valid / cfg_ready timeout_seconds
//
// One item is worked on at a time. A query's result is staged on the accepting
// edge and posted to the output register from S_FIN. For a reply, the accepting
// edge compares every slot; in S_RSEL the newest hit is picked and the gap
// closed, then S_FIN posts the result. A tick circulates every entry once
// past the aging unit at the head of the chain (S_ROT), then compacts the
// table (S_PACK) and posts the result (S_FIN). The next beat is taken once the
// result is posted and the block is back in S_IDLE.
// Reset (rst, synchronous) empties the table and loads a timeout of 10 seconds.
// A stalled result sits in the output register; the block finishes the next
// item behind it and holds that result until the output register frees up.
module pending_query_tracker_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] txn_id,
  input  wire logic [31:0] client_ip,
  input  wire logic [15:0] client_port,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [31:0]      reply_ip,
  output logic [15:0]      reply_port,
  output logic [4:0]       evicted_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  timeout_seconds
);
  import pqt_pkg::*;

  localparam int CW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RSEL = 3'd1;
  localparam logic [2:0] S_ROT  = 3'd2;
  localparam logic [2:0] S_PACK = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state;
  logic [CW-1:0] rot_cnt;
  logic [4:0]  evict_cnt;
  logic [7:0]  timeout;

  // Result staged for the output register.
  logic [2:0]  res_status;
  logic [31:0] res_ip;
  logic [15:0] res_port;
  logic [4:0]  res_ev;

  cell_ctrl_t ctrl;
  entry_t     ents [TABLE_DEPTH];
  entry_t     new_ent;
  entry_t     rot_ent;
  entry_t     last_right;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] move_vec;
  logic [TABLE_DEPTH-1:0] kill_vec;
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic        hit;
  logic [31:0] hit_ip;
  logic [15:0] hit_port;
  logic        in_acc;
  logic        full;
  logic        any_move;
  logic [7:0]  age_inc;
  logic        evict;
  logic        load_out;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign full      = ents[TABLE_DEPTH-1].valid;
  assign any_move  = |move_vec;
  assign load_out  = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    new_ent       = '0;
    new_ent.valid = 1'b1;
    new_ent.id    = txn_id;
    new_ent.ip    = client_ip;
    new_ent.port  = client_port;
  end

  // Aging unit at the head of the chain: during a tick every entry passes
  // through it once on its way around to the tail.
  assign age_inc = (ents[0].age == AGE_MAX) ? ents[0].age : ents[0].age + 8'd1;
  assign evict   = age_inc > timeout;

  always_comb begin
    rot_ent       = ents[0];
    rot_ent.age   = age_inc;
    rot_ent.valid = ents[0].valid && !evict;
  end

  assign last_right = (state == S_ROT) ? rot_ent : entry_t'('0);

  always_comb begin
    ctrl.txn_id = txn_id;
    ctrl.op     = OP_HOLD;
    unique case (state)
      S_IDLE: begin
        if (in_acc && (req_type == REQ_QUERY) && !full) begin
          ctrl.op = OP_SHR;
        end else if (in_acc && (req_type == REQ_REPLY)) begin
          ctrl.op = OP_MATCH;
        end
      end
      S_RSEL:  ctrl.op = OP_REMOVE;
      S_ROT:   ctrl.op = OP_ROT;
      S_PACK:  ctrl.op = OP_PACK;
      default: ctrl.op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t left_in;
    entry_t right_in;
    if (i == 0) begin : g_head
      assign left_in = new_ent;
    end else begin : g_mid
      assign left_in = ents[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_in = last_right;
    end else begin : g_body
      assign right_in = ents[i+1];
    end
    assign valid_vec[i] = ents[i].valid;

    pqt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .left_in  (left_in),
      .right_in (right_in),
      .kill     (kill_vec[i]),
      .entry    (ents[i]),
      .match    (match_vec[i]),
      .move     (move_vec[i])
    );
  end

  pqt_pick #(
    .DEPTH (TABLE_DEPTH)
  ) u_pick (
    .match    (match_vec),
    .ents     (ents),
    .kill     (kill_vec),
    .hit      (hit),
    .hit_ip   (hit_ip),
    .hit_port (hit_port)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rot_cnt   <= '0;
      evict_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (req_type == REQ_REPLY) begin
              state <= S_RSEL;
            end else if (req_type == REQ_TICK) begin
              state     <= S_ROT;
              rot_cnt   <= '0;
              evict_cnt <= '0;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RSEL: begin
          state <= S_FIN;
        end
        S_ROT: begin
          if (ents[0].valid && evict && (evict_cnt != EVICT_MAX)) begin
            evict_cnt <= evict_cnt + 5'd1;
          end
          if (rot_cnt == CW'(TABLE_DEPTH - 1)) begin
            state <= S_PACK;
          end else begin
            rot_cnt <= rot_cnt + CW'(1);
          end
        end
        S_PACK: begin
          if (!any_move) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Staged result; only written on the paths that produce it.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_acc) begin
      res_ip   <= '0;
      res_port <= '0;
      res_ev   <= '0;
      if (req_type == REQ_QUERY) begin
        res_status <= full ? ST_DROPPED : ST_STORED;
      end else begin
        res_status <= ST_TICK;
      end
    end else if (state == S_RSEL) begin
      res_status <= hit ? ST_MATCHED : ST_UNMATCHED;
      res_ip     <= hit_ip;
      res_port   <= hit_port;
    end else if ((state == S_PACK) && !any_move) begin
      res_status <= ST_TICK;
      res_ev     <= evict_cnt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= res_status;
      reply_ip      <= res_ip;
      reply_port    <= res_port;
      evicted_count <= res_ev;
    end
  end

  // Timeout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= timeout_seconds;
    end
  end

  // Valid slots always form a contiguous run from the head while idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("pending table not contiguous while idle");

  // An accepted query on a table with room lands at the head.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && (req_type == REQ_QUERY) && !full) |=>
      (ents[0].valid && (ents[0].id == $past(txn_id)) && (ents[0].age == 8'd0)))
    else $error("stored query missing from the head slot");

  // Only a matched reply carries an address.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_MATCHED)) |-> ((reply_ip == '0) && (reply_port == '0)))
    else $error("address present on a result that is not a match");

  // Evictions are reported only on a tick result.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (evicted_count != 5'd0)) |-> (status == ST_TICK))
    else $error("eviction count on a non-tick result");

endmodule

`default_nettype wire
